/* sv/dttf_pkg.sv */
// Shared types and constants for the decimal text to fixed point converter.
// Used by the parser, the finishing stage and the top level; depends on nothing.
package dttf_pkg;

	// Character codes that the parser recognizes.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Accumulator widths. The fraction field covers up to eighteen digits.
	localparam int INT_W      = 63;
	localparam int FRAC_MAX_W = 60;
	localparam int VALUE_W    = 64;

	// Powers of ten from 10^0 to 10^18.
	localparam int POW_IDX_W = 5;
	localparam logic [63:0] POW10_TAB [0:18] = '{
		64'd1,
		64'd10,
		64'd100,
		64'd1000,
		64'd10000,
		64'd100000,
		64'd1000000,
		64'd10000000,
		64'd100000000,
		64'd1000000000,
		64'd10000000000,
		64'd100000000000,
		64'd1000000000000,
		64'd10000000000000,
		64'd100000000000000,
		64'd1000000000000000,
		64'd10000000000000000,
		64'd100000000000000000,
		64'd1000000000000000000
	};

	// One parsed number handed from the parser to the finishing stage.
	// The integer part is already scaled by ten to the fraction digits,
	// and the fraction is already padded to the full digit count.
	typedef struct packed {
		logic                  negative;
		logic                  ok;
		logic [INT_W-1:0]      scaled_int;
		logic [FRAC_MAX_W-1:0] frac;
	} num_t;

endpackage

/* sv/dttf_char_if.sv */
// Character channel: one text byte per beat with its end mark.
// Depends on nothing.
interface dttf_char_if;
	logic       valid;
	logic       ready;
	logic       char_present;
	logic [7:0] character;
	logic       last_char;

	modport source(output valid, char_present, character, last_char, input ready);
	modport sink(input valid, char_present, character, last_char, output ready);
endinterface

/* sv/dttf_result_if.sv */
// Result channel: one signed fixed-point value and its ok flag per beat.
// Depends on nothing.
interface dttf_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] scaled_value;
	logic               parse_ok;

	modport source(output valid, scaled_value, parse_ok, input ready);
	modport sink(input valid, scaled_value, parse_ok, output ready);
endinterface

/* sv/dttf_parser.sv */
// Character parser: folds one byte per beat into the running number state and
// hands the finished number to the next stage. Depends on dttf_pkg, dttf_char_if.
module dttf_parser #(
	parameter int FRACTION_DIGITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	dttf_char_if.sink     text,
	output logic          num_valid,
	input  logic          num_ready,
	output dttf_pkg::num_t num
);
	import dttf_pkg::*;

	localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);
	localparam logic [63:0] SCALE = POW10_TAB[FRACTION_DIGITS];
	localparam int FRAC_W = $clog2(SCALE);

	// Running number state.
	logic [INT_W-1:0]  int_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic              seen_q;
	logic              in_frac_q;
	logic              first_q;
	logic              err_q;

	logic [INT_W-1:0]  int_d;
	logic [FRAC_W-1:0] frac_d;
	logic [CNT_W-1:0]  cnt_d;
	logic              neg_d;
	logic              seen_d;
	logic              in_frac_d;
	logic              err_d;

	logic              accept;
	logic              take;
	logic              is_digit;
	logic [3:0]        digit;
	logic [63:0]       int_term;
	logic [67:0]       int_prod;
	logic [POW_IDX_W-1:0] w_idx;
	logic [FRAC_W-1:0] weight;
	logic [FRAC_W+3:0] frac_term;

	// Snapshot register toward the finishing stage.
	logic              num_valid_s1;
	num_t              num_s1;

	assign text.ready = !num_valid_s1 || num_ready;
	assign accept     = text.valid && text.ready;
	assign take       = accept && text.char_present && !err_q;

	assign is_digit = (text.character >= CH_ZERO) && (text.character <= CH_NINE);
	assign digit    = text.character[3:0];

	// Integer digit: scaled accumulator times ten plus the digit times the scale.
	assign int_term = 64'(digit) * SCALE;
	assign int_prod = 68'({int_q, 3'b000}) + 68'({int_q, 1'b0}) + 68'(int_term);

	// Fraction digit: add the digit at its final decimal weight.
	assign w_idx     = POW_IDX_W'(FRACTION_DIGITS - 1) - POW_IDX_W'(cnt_q);
	assign weight    = FRAC_W'(POW10_TAB[w_idx]);
	assign frac_term = (FRAC_W + 4)'(weight) * (FRAC_W + 4)'(digit);

	// Next number state for one beat.
	always_comb begin
		int_d     = int_q;
		frac_d    = frac_q;
		cnt_d     = cnt_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		in_frac_d = in_frac_q;
		err_d     = err_q;
		if (take) begin
			if (first_q && text.character == CH_MINUS) begin
				neg_d = 1'b1;
			end else if (text.character == CH_POINT) begin
				if (in_frac_q) begin
					err_d = 1'b1;
				end else begin
					in_frac_d = 1'b1;
				end
			end else if (is_digit) begin
				seen_d = 1'b1;
				if (!in_frac_q) begin
					if (|int_prod[67:INT_W]) begin
						err_d = 1'b1;
					end else begin
						int_d = int_prod[INT_W-1:0];
					end
				end else if (cnt_q < CNT_W'(FRACTION_DIGITS)) begin
					frac_d = frac_q + frac_term[FRAC_W-1:0];
					cnt_d  = cnt_q + CNT_W'(1);
				end
			end else begin
				err_d = 1'b1;
			end
		end
	end

	// Control state; the number clears itself after its last beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			neg_q        <= 1'b0;
			seen_q       <= 1'b0;
			in_frac_q    <= 1'b0;
			first_q      <= 1'b1;
			err_q        <= 1'b0;
			num_valid_s1 <= 1'b0;
		end else begin
			if (accept && text.last_char) begin
				cnt_q     <= '0;
				neg_q     <= 1'b0;
				seen_q    <= 1'b0;
				in_frac_q <= 1'b0;
				first_q   <= 1'b1;
				err_q     <= 1'b0;
			end else if (accept) begin
				cnt_q     <= cnt_d;
				neg_q     <= neg_d;
				seen_q    <= seen_d;
				in_frac_q <= in_frac_d;
				err_q     <= err_d;
				if (text.char_present) begin
					first_q <= 1'b0;
				end
			end
			if (accept && text.last_char) begin
				num_valid_s1 <= 1'b1;
			end else if (num_ready) begin
				num_valid_s1 <= 1'b0;
			end
		end
	end

	// Accumulators and the handed-off number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= '0;
			frac_q <= '0;
		end else if (accept && text.last_char) begin
			int_q  <= '0;
			frac_q <= '0;
		end else if (accept) begin
			int_q  <= int_d;
			frac_q <= frac_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && text.last_char) begin
			num_s1.negative   <= neg_d;
			num_s1.ok         <= seen_d && !err_d;
			num_s1.scaled_int <= int_d;
			num_s1.frac       <= FRAC_MAX_W'(frac_d);
		end
	end

	assign num_valid = num_valid_s1;
	assign num       = num_s1;

	// A finished number leaves the parser ready for the first character of the next.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.last_char |=> first_q && !err_q && cnt_q == '0 && !in_frac_q)
		else $error("parser state not cleared after last beat");

	// An error sticks until the number ends.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(accept && text.last_char) |=> err_q)
		else $error("error flag dropped inside a number");

	// A held number is not overwritten.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid_s1 && !num_ready |=> num_valid_s1 && $stable(num_s1))
		else $error("pending number lost");

	// The kept fraction digit count never passes the configured digits.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FRACTION_DIGITS))
		else $error("fraction digit count out of range");

endmodule

/* sv/dttf_finish.sv */
// Finishing stage: adds integer and fraction, checks the 63-bit range, applies
// the sign and holds the result beat. Depends on dttf_pkg, dttf_result_if.
module dttf_finish (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           num_valid,
	output logic           num_ready,
	input  dttf_pkg::num_t num,
	dttf_result_if.source  result
);
	import dttf_pkg::*;

	logic               valid_s2;
	logic               ok_s2;
	logic               neg_s2;
	logic [INT_W-1:0]   mag_s2;
	logic [VALUE_W-1:0] sum;
	logic               out_free;
	logic               valid_q;
	logic               ok_q;
	logic [VALUE_W-1:0] value_q;

	assign out_free  = !valid_q || result.ready;
	assign num_ready = !valid_s2 || out_free;

	// Range check on the full magnitude.
	assign sum = VALUE_W'(num.scaled_int) + VALUE_W'(num.frac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (num_ready) begin
				valid_s2 <= num_valid;
			end
			if (out_free) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (num_ready && num_valid) begin
			ok_s2  <= num.ok && !sum[VALUE_W-1];
			neg_s2 <= num.negative;
			mag_s2 <= sum[INT_W-1:0];
		end
	end

	// Result register: signed value, zero when the parse failed.
	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			ok_q <= ok_s2;
			if (!ok_s2) begin
				value_q <= '0;
			end else if (neg_s2) begin
				value_q <= VALUE_W'(0) - VALUE_W'(mag_s2);
			end else begin
				value_q <= VALUE_W'(mag_s2);
			end
		end
	end

	assign result.valid        = valid_q;
	assign result.parse_ok     = ok_q;
	assign result.scaled_value = value_q;

	// A rejected number always reads as zero.
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ok_q |-> value_q == '0)
		else $error("failed parse carries a nonzero value");

	// A stalled middle stage keeps its number.
	a_hold_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(mag_s2) && $stable(ok_s2))
		else $error("middle stage lost a number");

	// A valid positive result never has the sign bit set.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ok_s2 && out_free && !neg_s2 |=> !value_q[VALUE_W-1])
		else $error("positive result out of range");

endmodule

/* sv/decimal_text_to_fixed_point.sv */
// Top level of the decimal text to fixed point converter.
// Depends on dttf_pkg, dttf_char_if, dttf_result_if, dttf_parser and dttf_finish.
//
// Usage:
//   The text channel takes one beat per character: char_present marks a real
//   byte, last_char ends the number (a beat with char_present low and last_char
//   high ends it without a byte; with both low the beat does nothing).
//   For every beat with last_char high the result channel gives one beat:
//   the value times ten to FRACTION_DIGITS in two's complement and parse_ok.
//   parse_ok is low, and the value zero, for empty text, a bad byte, a minus
//   that is not first, a second point, or a magnitude above 2^63-1.
//   Throughput is one character per clock while ready is high. A result passes
//   the parser snapshot, the range add, then the sign and result register.
//   The per-character accumulate step sets the clock. When the receiver
//   stalls, up to three finished numbers wait in the pipeline and characters
//   keep flowing; once all three slots are full, ready stays low until the
//   receiver takes a result.
//   Reset clears the pending results and leaves the parser at the start of a
//   new number.
module decimal_text_to_fixed_point #(
	parameter int FRACTION_DIGITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	dttf_char_if.sink      text,
	dttf_result_if.source  result
);
	import dttf_pkg::*;

	logic num_valid;
	logic num_ready;
	num_t num;

	// Character accumulation.
	dttf_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num      (num)
	);

	// Range check, sign and result beat.
	dttf_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num      (num),
		.result   (result)
	);

endmodule
